// ----- rtl/core/spd_pkg.sv -----
// Package for the shortest-path core: word layouts, request and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package spd_pkg;

	localparam int REQ_TYPE_BITS   = 2;
	localparam int NODE_ID_BITS    = 4;
	localparam int EDGE_COST_BITS  = 12;
	localparam int STATUS_BITS     = 2;
	localparam int PATH_COST_BITS  = 16;
	localparam int NODE_COUNT_BITS = 5;

	localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RST = 5'd5;
	localparam logic [PATH_COST_BITS-1:0]  COST_MAX       = 16'hFFFF;

	// Request codes
	localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] STATUS_FOUND    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_UNREACH  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_BAD_NODE = 2'd2;

	typedef struct packed {
		logic [REQ_TYPE_BITS-1:0]  req_type;
		logic [NODE_ID_BITS-1:0]   node_a;
		logic [NODE_ID_BITS-1:0]   node_b;
		logic [EDGE_COST_BITS-1:0] edge_cost;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]    status;
		logic [PATH_COST_BITS-1:0] path_cost;
	} rsp_word_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR1,
		S_ADD_WR2,
		S_SETTLE,
		S_RELAX,
		S_DRAIN,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                   sweep_step;
		logic                   load_req;
		logic                   q_init;
		logic                   add_wr1;
		logic                   add_wr2;
		logic                   settle;
		logic                   relax_step;
		logic                   next_round;
		logic                   res_set;
		logic [STATUS_BITS-1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic nodes_ok;
		logic sweep_last;
		logic v_last;
		logic pipe_busy;
		logic found;
		logic at_target;
	} dp_stat_t;

endpackage

// ----- rtl/core/shortest_path_dijkstra_core.sv -----
// Shortest-path core top: controller, datapath and the response register. Add loads the request,
// reads the edge, then writes both directions; clear sweeps all 2^(2*clog2(NODES)) edge entries.
// Query: for each settled node, settle it, scan its edge row up to the node limit and drain the
// relax pipeline; a bad id ends at once. A new request is taken only once the core is back in idle.
// Reset: arst_n clears control state and node_count to 5, then runs the edge clear sweep
// (same length as a clear) with req_stall high; config writes are taken throughout.
module shortest_path_dijkstra_core #(
	parameter int NODES       = 16,
	parameter int WEIGHT_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [spd_pkg::NODE_COUNT_BITS-1:0] cfg_wr_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  spd_pkg::req_word_t                  req_word,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output spd_pkg::rsp_word_t                  rsp_word
);
	import spd_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	rsp_word_t result;
	logic      post;
	logic      rsp_busy;
	logic      rsp_valid_q;
	rsp_word_t rsp_word_q;

	// The response slot stays busy only while a held word is still stalled
	assign rsp_busy = rsp_valid_q && rsp_stall;

	// Controller: walks clear, add and search sequences, one request word at a time
	spd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_word.req_type),
		.rsp_busy  (rsp_busy),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall),
		.post      (post)
	);

	// Datapath: edge memory, distances, relax pipeline and result word
	spd_dpath #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_word    (req_word),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result)
	);

	// Response register: load on post, drop valid once the word is taken.
	// A new request can be taken while a finished word still waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (post) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled; only post changes it
	always_ff @(posedge clk) begin
		if (post) begin
			rsp_word_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef NO_ASSERTIONS
	// Never overwrite a response word that is still stalled
	post_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		post |-> (!rsp_valid || !rsp_stall))
		else $error("response posted over a stalled word");

	// Only a found path carries a cost
	cost_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_word.status == STATUS_FOUND) || (rsp_word.path_cost == '0)))
		else $error("nonzero cost on a failed query");

	// Memory-touching commands are mutually exclusive
	one_step_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep_step, cmd.add_wr1, cmd.add_wr2, cmd.settle,
			cmd.relax_step, cmd.next_round}))
		else $error("overlapping datapath commands");

	// Requests are taken only with the relax pipeline empty
	idle_means_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !stat.pipe_busy)
		else $error("request taken while relax pipeline busy");
`endif

endmodule

// ----- rtl/core/spd_dpath.sv -----
// Datapath of the shortest-path core: node_count register, edge memory,
// distance memory, relax pipeline and minimum tracker, result register.
// Depends on spd_pkg.
module spd_dpath #(
	parameter int NODES       = 16,
	parameter int WEIGHT_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [spd_pkg::NODE_COUNT_BITS-1:0] cfg_wr_data,
	input  spd_pkg::req_word_t                  req_word,
	input  spd_pkg::dp_cmd_t                    cmd,
	output spd_pkg::dp_stat_t                   stat,
	output spd_pkg::rsp_word_t                  result
);
	import spd_pkg::*;

	localparam int NB         = $clog2(NODES);
	localparam int ADDR_BITS  = 2 * NB;
	localparam int EDGE_DEPTH = 1 << ADDR_BITS;
	localparam int DIST_BITS  = WEIGHT_BITS + NB;
	localparam int LIM_BITS   = ($clog2(NODES + 1) > NODE_COUNT_BITS) ?
		$clog2(NODES + 1) : NODE_COUNT_BITS;
	localparam int CMP_BITS   = (DIST_BITS > PATH_COST_BITS) ? DIST_BITS : PATH_COST_BITS;

	logic [NODE_COUNT_BITS-1:0] node_count_q;
	logic [LIM_BITS-1:0]        lim;

	logic [NB-1:0]          a_q, b_q, a_in;
	logic [WEIGHT_BITS-1:0] w_q;
	logic                   add_upd, add_upd_q;

	logic [WEIGHT_BITS:0] edge_mem [EDGE_DEPTH];
	logic [WEIGHT_BITS:0] edge_rd_s1;
	logic                 edge_we;
	logic [ADDR_BITS-1:0] edge_wa, edge_ra;
	logic [WEIGHT_BITS:0] edge_wd;
	logic [ADDR_BITS-1:0] sweep_q;

	logic [DIST_BITS-1:0] dist_mem [NODES];
	logic [DIST_BITS-1:0] dist_rd_s1;

	logic [NODES-1:0]     reached_q, settled_q;
	logic [NB-1:0]        u_q, v_q, v_s1, v_s2, min_v_q;
	logic [DIST_BITS-1:0] du_q, min_d_q;
	logic                 found_q;
	logic                 valid_s1, valid_s2;

	logic                 upd_s1, cand_s1, cand_s2;
	logic [DIST_BITS-1:0] d_s1, new_d_s1, cand_d_s2;

	logic [CMP_BITS-1:0]       du_ext;
	logic [PATH_COST_BITS-1:0] cost_sat;
	rsp_word_t                 res_q;

	// Node limit and request checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	assign lim = (LIM_BITS'(node_count_q) < LIM_BITS'(NODES)) ?
		LIM_BITS'(node_count_q) : LIM_BITS'(NODES);
	assign a_in = NB'(req_word.node_a);

	assign stat.nodes_ok = (LIM_BITS'(req_word.node_a) < lim) &&
		(LIM_BITS'(req_word.node_b) < lim);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			a_q <= a_in;
			b_q <= NB'(req_word.node_b);
			w_q <= WEIGHT_BITS'(req_word.edge_cost);
		end
		if (cmd.add_wr1) begin
			add_upd_q <= add_upd;
		end
	end

	// Edge memory: sweep clears, add does read-compare-write, relax reads a row
	assign add_upd = !edge_rd_s1[WEIGHT_BITS] || (w_q < edge_rd_s1[WEIGHT_BITS-1:0]);
	assign edge_ra = cmd.relax_step ? {u_q, v_q} : {a_q, b_q};

	always_comb begin
		edge_we = 1'b0;
		edge_wa = sweep_q;
		edge_wd = {1'b0, w_q};
		if (cmd.sweep_step) begin
			edge_we = 1'b1;
		end else if (cmd.add_wr1) begin
			edge_we = add_upd;
			edge_wa = {a_q, b_q};
			edge_wd = {1'b1, w_q};
		end else if (cmd.add_wr2) begin
			edge_we = add_upd_q;
			edge_wa = {b_q, a_q};
			edge_wd = {1'b1, w_q};
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_s1 <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_q <= sweep_q + ADDR_BITS'(1);
		end
	end
	assign stat.sweep_last = &sweep_q;

	// Relax stage: settled u against row entry v
	assign d_s1     = du_q + DIST_BITS'(edge_rd_s1[WEIGHT_BITS-1:0]);
	assign upd_s1   = valid_s1 && edge_rd_s1[WEIGHT_BITS] && !settled_q[v_s1] &&
		(!reached_q[v_s1] || (d_s1 < dist_rd_s1));
	assign new_d_s1 = upd_s1 ? d_s1 : dist_rd_s1;
	assign cand_s1  = valid_s1 && (reached_q[v_s1] || upd_s1) && !settled_q[v_s1];

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			dist_mem[v_s1] <= d_s1;
		end
		dist_rd_s1 <= dist_mem[v_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			settled_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			found_q   <= 1'b0;
			v_q       <= '0;
		end else begin
			valid_s1 <= cmd.relax_step;
			valid_s2 <= valid_s1;
			if (cmd.q_init) begin
				reached_q <= NODES'(1) << a_in;
				settled_q <= '0;
			end else begin
				if (cmd.settle) begin
					settled_q[u_q] <= 1'b1;
				end
				if (upd_s1) begin
					reached_q[v_s1] <= 1'b1;
				end
			end
			if (cmd.settle) begin
				v_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.relax_step) begin
					v_q <= v_q + NB'(1);
				end
				if (valid_s2 && cand_s2 && (!found_q || (cand_d_s2 < min_d_q))) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Minimum tracker, strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		v_s1      <= v_q;
		v_s2      <= v_s1;
		cand_s2   <= cand_s1;
		cand_d_s2 <= new_d_s1;
		if (!cmd.settle && valid_s2 && cand_s2 && (!found_q || (cand_d_s2 < min_d_q))) begin
			min_v_q <= v_s2;
			min_d_q <= cand_d_s2;
		end
		if (cmd.q_init) begin
			u_q  <= a_in;
			du_q <= '0;
		end else if (cmd.next_round) begin
			u_q  <= min_v_q;
			du_q <= min_d_q;
		end
	end

	assign stat.v_last    = (LIM_BITS'(v_q) == (lim - LIM_BITS'(1)));
	assign stat.pipe_busy = valid_s1 || valid_s2;
	assign stat.found     = found_q;
	assign stat.at_target = (u_q == b_q);

	// Result register, cost clamps to the field range
	assign du_ext   = CMP_BITS'(du_q);
	assign cost_sat = (du_ext > CMP_BITS'(COST_MAX)) ? COST_MAX : PATH_COST_BITS'(du_q);

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q.status    <= cmd.res_status;
			res_q.path_cost <= (cmd.res_status == STATUS_FOUND) ? cost_sat : '0;
		end
	end
	assign result = res_q;

endmodule

// ----- rtl/core/spd_ctrl.sv -----
// Controller of the shortest-path core: sequences sweep, add and search steps.
// Depends on spd_pkg.
module spd_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [spd_pkg::REQ_TYPE_BITS-1:0] req_type,
	input  logic                              rsp_busy,
	input  spd_pkg::dp_stat_t                 stat,
	output spd_pkg::dp_cmd_t                  cmd,
	output logic                              req_stall,
	output logic                              post
);
	import spd_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		post      = 1'b0;
		case (state_q)
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (req_type)
						REQ_CLEAR: begin
							state_d = S_SWEEP;
						end
						REQ_ADD: begin
							if (stat.nodes_ok) begin
								cmd.load_req = 1'b1;
								state_d      = S_ADD_RD;
							end
						end
						REQ_QUERY: begin
							cmd.load_req = 1'b1;
							if (stat.nodes_ok) begin
								cmd.q_init = 1'b1;
								state_d    = S_SETTLE;
							end else begin
								cmd.res_set    = 1'b1;
								cmd.res_status = STATUS_BAD_NODE;
								state_d        = S_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD_RD: begin
				state_d = S_ADD_WR1;
			end
			S_ADD_WR1: begin
				cmd.add_wr1 = 1'b1;
				state_d     = S_ADD_WR2;
			end
			S_ADD_WR2: begin
				cmd.add_wr2 = 1'b1;
				state_d     = S_IDLE;
			end
			S_SETTLE: begin
				cmd.settle = 1'b1;
				if (stat.at_target) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = STATUS_FOUND;
					state_d        = S_DONE;
				end else begin
					state_d = S_RELAX;
				end
			end
			S_RELAX: begin
				cmd.relax_step = 1'b1;
				if (stat.v_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					if (stat.found) begin
						cmd.next_round = 1'b1;
						state_d        = S_SETTLE;
					end else begin
						cmd.res_set    = 1'b1;
						cmd.res_status = STATUS_UNREACH;
						state_d        = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!rsp_busy) begin
					post    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
	end

endmodule
